// ===== hw/rtl/ppat_pkg.sv =====
// ----------------------------------------------------------------------------
// ppat_pkg: shared types and constants for the pixel point average table
// Opcodes, status codes, state encoding and memory geometry.
// ----------------------------------------------------------------------------
package ppat_pkg;

  localparam int MaxPixels = 1048576;
  localparam int IdxBits   = $clog2(MaxPixels);
  localparam int CountBits = 16;
  localparam int SumBits   = 48;
  localparam int CsumBits  = 24;

  localparam logic [2:0] OP_SET      = 3'd0;
  localparam logic [2:0] OP_SET_COL  = 3'd1;
  localparam logic [2:0] OP_ADD      = 3'd2;
  localparam logic [2:0] OP_ADD_COL  = 3'd3;
  localparam logic [2:0] OP_GET      = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOCOLOR  = 3'd3;
  localparam logic [2:0] ST_SATURATE = 3'd4;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_COLOR   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_INDEX, S_READ, S_MODIFY, S_DIVIDE, S_OUT
  } state_t;

endpackage

// ===== hw/rtl/pixel_point_average_table.sv =====
// ----------------------------------------------------------------------------
// pixel_point_average_table: per-pixel point/colour averaging table
// Read-modify-write of sums and counts in one memory per field; gets divide
// point sums, and colour sums if enabled, by the count in a shared restoring divider.
// ----------------------------------------------------------------------------
// channel  dir  beat contents
// s_axis   in   tdata: opcode, col, row, point_x/y/z, color_c0..c2
// m_axis   out  tdata: status, avg_x/y/z, avg_c0..c2, hit_count
// cfg      in   cfg_we, cfg_index, cfg_data
//
// Set/add: a beat steps through index multiply, range check, memory read,
// write back and out; any out-of-range beat skips from range check to out.
// Get: the serial divider (one bit a cycle) runs between write back and
// out over six sums, three with colour disabled; an empty pixel skips it.
// After reset the count memory is swept to zero, one entry a cycle, over
// all MaxPixels (1048576) entries; no beat is taken meanwhile.
// The result register holds a beat while m_axis_tready is low; no new beat
// is taken until it drains.
// ----------------------------------------------------------------------------
module pixel_point_average_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[2:0] col[14:3] row[26:15] point_x[58:27] point_y[90:59]
  // point_z[122:91] color_c0[130:123] color_c1[138:131] color_c2[146:139]
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0] avg_x[34:3] avg_y[66:35] avg_z[98:67] avg_c0[106:99]
  // avg_c1[114:107] avg_c2[122:115] hit_count[138:123]
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  localparam int IB = ppat_pkg::IdxBits;
  localparam int SB = ppat_pkg::SumBits;
  localparam int CB = ppat_pkg::CsumBits;
  localparam int NB = ppat_pkg::CountBits;
  localparam logic [NB-1:0] CountMax = {NB{1'b1}};

  logic [12:0] image_width, image_height;
  logic        color_enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd1024;
      image_height  <= 13'd768;
      color_enabled <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ppat_pkg::REG_WIDTH:  image_width   <= cfg_data;
        ppat_pkg::REG_HEIGHT: image_height  <= cfg_data;
        ppat_pkg::REG_COLOR:  color_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // memories
  logic [SB-1:0] mem_x [ppat_pkg::MaxPixels];
  logic [SB-1:0] mem_y [ppat_pkg::MaxPixels];
  logic [SB-1:0] mem_z [ppat_pkg::MaxPixels];
  logic [CB-1:0] mem_c0 [ppat_pkg::MaxPixels];
  logic [CB-1:0] mem_c1 [ppat_pkg::MaxPixels];
  logic [CB-1:0] mem_c2 [ppat_pkg::MaxPixels];
  logic [NB-1:0] mem_n [ppat_pkg::MaxPixels];

  ppat_pkg::state_t state, state_next;

  logic [2:0]  op;
  logic [11:0] col, row;
  logic [31:0] px, py, pz;
  logic [7:0]  c0, c1, c2;
  logic [24:0] idx_full;
  logic        in_range;
  logic [IB-1:0] clr_cnt;

  logic [SB-1:0] rx, ry, rz;
  logic [CB-1:0] rc0, rc1, rc2;
  logic [NB-1:0] rn;

  logic [2:0]    status;
  logic [NB-1:0] n_new;
  logic          sum_we, col_we, is_set;

  logic [SB-1:0] px_w, py_w, pz_w;
  logic [IB-1:0] idx;
  logic          with_color;

  assign idx        = idx_full[IB-1:0];
  assign px_w       = {{(SB-32){px[31]}}, px};
  assign py_w       = {{(SB-32){py[31]}}, py};
  assign pz_w       = {{(SB-32){pz[31]}}, pz};
  assign with_color = (op == ppat_pkg::OP_SET_COL) || (op == ppat_pkg::OP_ADD_COL);
  assign in_range   = ({1'b0, col} < image_width) && ({1'b0, row} < image_height)
                      && (idx_full < 25'(ppat_pkg::MaxPixels));

  // divider
  logic [2:0]    div_sel;
  logic [5:0]    div_bit;
  logic [SB-1:0] div_num, div_quo;
  logic [SB:0]   div_rem;
  logic          div_neg;
  logic [SB:0]   div_trial;
  logic [31:0]   avg_x, avg_y, avg_z;
  logic [7:0]    avg_c0, avg_c1, avg_c2;

  assign div_trial = {div_rem[SB-1:0], div_num[SB-1]} - {{(SB+1-NB){1'b0}}, rn};

  always_comb begin
    state_next = state;
    case (state)
      ppat_pkg::S_CLEAR:
        if (clr_cnt == IB'(ppat_pkg::MaxPixels - 1)) state_next = ppat_pkg::S_IDLE;
      ppat_pkg::S_IDLE:   if (s_axis_tvalid) state_next = ppat_pkg::S_INDEX;
      ppat_pkg::S_INDEX:  state_next = in_range ? ppat_pkg::S_READ : ppat_pkg::S_OUT;
      ppat_pkg::S_READ:   state_next = ppat_pkg::S_MODIFY;
      ppat_pkg::S_MODIFY:
        state_next = (op == ppat_pkg::OP_GET && rn != '0) ? ppat_pkg::S_DIVIDE : ppat_pkg::S_OUT;
      ppat_pkg::S_DIVIDE:
        if (div_bit == 6'd0 && (div_sel == 3'd5 || (div_sel == 3'd2 && !color_enabled)))
          state_next = ppat_pkg::S_OUT;
      ppat_pkg::S_OUT:    if (m_axis_tready) state_next = ppat_pkg::S_IDLE;
      default:            state_next = ppat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ppat_pkg::S_IDLE);
    m_axis_tvalid = (state == ppat_pkg::S_OUT);
    m_axis_tdata  = {5'd0, rn, avg_c2, avg_c1, avg_c0, avg_z, avg_y, avg_x, status};
  end

  always_comb begin
    is_set = (op == ppat_pkg::OP_SET) || (op == ppat_pkg::OP_SET_COL) || (rn == '0);
    sum_we = 1'b0;
    col_we = 1'b0;
    n_new  = rn;
    if (op <= ppat_pkg::OP_ADD_COL) begin
      if (is_set) begin
        sum_we = 1'b1; n_new = NB'(1);
      end else if (rn != CountMax) begin
        sum_we = 1'b1; n_new = rn + NB'(1);
      end
      col_we = sum_we && with_color && color_enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ppat_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ppat_pkg::S_CLEAR) clr_cnt <= clr_cnt + IB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ppat_pkg::S_CLEAR) mem_n[clr_cnt] <= '0;
    else if (state == ppat_pkg::S_MODIFY) mem_n[idx] <= n_new;
    if (state == ppat_pkg::S_MODIFY && sum_we) begin
      mem_x[idx] <= is_set ? px_w : rx + px_w;
      mem_y[idx] <= is_set ? py_w : ry + py_w;
      mem_z[idx] <= is_set ? pz_w : rz + pz_w;
    end
    if (state == ppat_pkg::S_MODIFY && col_we) begin
      mem_c0[idx] <= is_set ? CB'(c0) : rc0 + CB'(c0);
      mem_c1[idx] <= is_set ? CB'(c1) : rc1 + CB'(c1);
      mem_c2[idx] <= is_set ? CB'(c2) : rc2 + CB'(c2);
    end
    if (state == ppat_pkg::S_READ) begin
      rx <= mem_x[idx]; ry <= mem_y[idx]; rz <= mem_z[idx];
      rc0 <= mem_c0[idx]; rc1 <= mem_c1[idx]; rc2 <= mem_c2[idx];
      rn <= mem_n[idx];
    end else if (state == ppat_pkg::S_MODIFY) begin
      rn <= n_new;
    end else if (state == ppat_pkg::S_INDEX && !in_range) begin
      rn <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ppat_pkg::S_IDLE: begin
        op  <= s_axis_tdata[2:0];
        col <= s_axis_tdata[14:3];
        row <= s_axis_tdata[26:15];
        px  <= s_axis_tdata[58:27];
        py  <= s_axis_tdata[90:59];
        pz  <= s_axis_tdata[122:91];
        c0  <= s_axis_tdata[130:123];
        c1  <= s_axis_tdata[138:131];
        c2  <= s_axis_tdata[146:139];
        idx_full <= 25'(s_axis_tdata[14:3]) * 25'(image_height) + 25'(s_axis_tdata[26:15]);
      end
      ppat_pkg::S_INDEX: begin
        avg_x <= '0; avg_y <= '0; avg_z <= '0;
        avg_c0 <= '0; avg_c1 <= '0; avg_c2 <= '0;
        status <= in_range ? ppat_pkg::ST_OK : ppat_pkg::ST_RANGE;
      end
      ppat_pkg::S_MODIFY: begin
        if (op <= ppat_pkg::OP_ADD_COL) begin
          if (!sum_we) status <= ppat_pkg::ST_SATURATE;
          else if (with_color && !color_enabled) status <= ppat_pkg::ST_NOCOLOR;
        end else if (op == ppat_pkg::OP_GET) begin
          if (rn == '0) status <= ppat_pkg::ST_EMPTY;
          else if (!color_enabled) status <= ppat_pkg::ST_NOCOLOR;
        end
        div_sel <= 3'd0;
        div_bit <= 6'(SB - 1);
        div_rem <= '0;
        div_neg <= rx[SB-1];
        div_num <= rx[SB-1] ? -rx : rx;
      end
      ppat_pkg::S_DIVIDE: begin
        if (div_bit != 6'd0) begin
          // one quotient bit a cycle
          if (div_trial[SB]) begin
            div_rem <= {div_rem[SB-1:0], div_num[SB-1]};
            div_quo <= {div_quo[SB-2:0], 1'b0};
          end else begin
            div_rem <= div_trial;
            div_quo <= {div_quo[SB-2:0], 1'b1};
          end
          div_num <= {div_num[SB-2:0], 1'b0};
          div_bit <= div_bit - 6'd1;
        end else begin
          logic [SB-1:0] q;
          logic [SB-1:0] sq;
          logic [31:0]   cm;
          logic [7:0]    cc;
          q  = {div_quo[SB-2:0], ~div_trial[SB]};
          sq = div_neg ? -q : q;
          if (!div_neg && q > SB'(32'h7fffffff)) cm = 32'h7fffffff;
          else if (div_neg && q > SB'(33'h80000000)) cm = 32'h80000000;
          else cm = sq[31:0];
          cc = (q > SB'(255)) ? 8'd255 : q[7:0];
          case (div_sel)
            3'd0: avg_x <= cm;
            3'd1: avg_y <= cm;
            3'd2: avg_z <= cm;
            3'd3: avg_c0 <= cc;
            3'd4: avg_c1 <= cc;
            default: avg_c2 <= cc;
          endcase
          div_sel <= div_sel + 3'd1;
          div_bit <= 6'(SB - 1);
          div_rem <= '0;
          case (div_sel)
            3'd0: begin div_neg <= ry[SB-1]; div_num <= ry[SB-1] ? -ry : ry; end
            3'd1: begin div_neg <= rz[SB-1]; div_num <= rz[SB-1] ? -rz : rz; end
            3'd2: begin div_neg <= 1'b0; div_num <= {{(SB-CB){1'b0}}, rc0}; end
            3'd3: begin div_neg <= 1'b0; div_num <= {{(SB-CB){1'b0}}, rc1}; end
            default: begin div_neg <= 1'b0; div_num <= {{(SB-CB){1'b0}}, rc2}; end
          endcase
        end
      end
      default: ;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == ppat_pkg::S_OUT) else $error("result outside OUT");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open while result pending");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == ppat_pkg::ST_RANGE) |-> rn == '0) else $error("count on range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");

endmodule
